// ----- rtl/stcs_pkg.sv -----
// shared types, constants and codes for the settle-then-collect statistics unit
package stcs_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int DIVIDEND_W       = 64;
	localparam int DIVISOR_W        = 16;
	localparam int CFG_ADDR_W       = 5;

	localparam logic [15:0] HOLD_TICKS_RST    = 16'd1;
	localparam logic [15:0] COLLECT_COUNT_RST = 16'd1;
	localparam logic [31:0] TIMEOUT_LIMIT_RST = 32'd1000;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_EXCITE   = 3'd1,
		PH_SETTLE   = 3'd2,
		PH_COLLECT  = 3'd3,
		PH_EVALUATE = 3'd4,
		PH_PASS     = 3'd5,
		PH_NOGO     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		REQ_BEGIN = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_PASS  = 2'd2,
		REQ_NOGO  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		REG_TARGET  = 3'd0,
		REG_BAND    = 3'd1,
		REG_HOLD    = 3'd2,
		REG_COLLECT = 3'd3,
		REG_TIMEOUT = 3'd4,
		REG_WINDOW  = 3'd5,
		REG_SPREAD  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] target_level;
		logic [30:0]        band_width;
		logic [15:0]        hold_ticks;
		logic [15:0]        collect_count;
		logic [31:0]        timeout_limit;
		logic [4:0]         window_length;
		logic signed [31:0] spread_limit;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_BEGIN,
		OP_TO_SETTLE,
		OP_TO_PASS,
		OP_TO_NOGO,
		OP_WIN_INST,
		OP_WIN_READ,
		OP_WIN_UPD,
		OP_WIN_DIV,
		OP_WIN_MEAN,
		OP_BAND,
		OP_C_DIV,
		OP_C_MEAN,
		OP_C_MUL,
		OP_C_ACC,
		OP_C_DIV2,
		OP_C_SQRT,
		OP_C_SPREAD,
		OP_C_END,
		OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_WAIT,
		S_DECODE,
		S_WIN_READ,
		S_WIN_UPD,
		S_WIN_DIVS,
		S_WIN_DIVW,
		S_WIN_MEAN,
		S_BAND,
		S_C_DIVS,
		S_C_DIVW,
		S_C_MEAN,
		S_C_MUL,
		S_C_ACC,
		S_C_CHK,
		S_C_DIV2S,
		S_C_DIV2W,
		S_C_SQS,
		S_C_SQW,
		S_C_SPREAD,
		S_C_END,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		req_t   req;
		phase_t phase;
		logic   begin_ok;
		logic   timed_out;
		logic   win_zero;
		logic   multi_sample;
		logic   div_busy;
		logic   sqrt_busy;
		logic   out_free;
	} dp_status_t;

endpackage

// ----- rtl/stcs_ifs.sv -----
// request and result channel interfaces

interface stcs_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] sample_value;
	logic [31:0]        time_ms;

	modport source (output valid, req_type, sample_value, time_ms, input ready);
	modport sink (input valid, req_type, sample_value, time_ms, output ready);
endinterface

interface stcs_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         phase_code;
	logic signed [31:0] stat_mean;
	logic [30:0]        stat_spread;
	logic signed [31:0] smoothed_value;
	logic [15:0]        samples_used;

	modport source (output valid, phase_code, stat_mean, stat_spread, smoothed_value,
		samples_used, input ready);
	modport sink (input valid, phase_code, stat_mean, stat_spread, smoothed_value,
		samples_used, output ready);
endinterface

// ----- rtl/stcs_divider.sv -----
// shared unsigned restoring divider, two quotient bits per cycle
module stcs_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [stcs_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [stcs_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                busy,
	output logic [stcs_pkg::DIVIDEND_W-1:0]     quotient
);
	localparam int NW    = stcs_pkg::DIVIDEND_W;
	localparam int DW    = stcs_pkg::DIVISOR_W;
	localparam int STEPS = NW / 2;
	localparam int CW    = $clog2(STEPS);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_nx;
	logic [NW-1:0] quo_nx;

	always_comb begin
		logic [DW:0]   t;
		logic [DW-1:0] r;
		logic [NW-1:0] q;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < 2; i++) begin
			t = {r, q[NW-1]};
			q = {q[NW-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				t    = t - {1'b0, dsr_q};
				q[0] = 1'b1;
			end
			r = t[DW-1:0];
		end
		rem_nx = r;
		quo_nx = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/stcs_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module stcs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] operand,
	output logic        busy,
	output logic [31:0] root
);
	logic        busy_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (busy_q && bit_q[1:0] != 2'b00)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[31:0];
endmodule

// ----- rtl/stcs_ctrl.sv -----
// sequencing state machine for one request transaction
module stcs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  stcs_pkg::dp_status_t   status,
	output stcs_pkg::dp_op_t       op
);
	stcs_pkg::ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= stcs_pkg::S_WAIT;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			stcs_pkg::S_WAIT: begin
				if (in_valid)
					state_nx = stcs_pkg::S_DECODE;
			end
			stcs_pkg::S_DECODE: begin
				state_nx = stcs_pkg::S_DONE;
				if (status.req == stcs_pkg::REQ_TICK) begin
					if (status.phase == stcs_pkg::PH_SETTLE && !status.timed_out)
						state_nx = status.win_zero ? stcs_pkg::S_BAND : stcs_pkg::S_WIN_READ;
					else if (status.phase == stcs_pkg::PH_COLLECT)
						state_nx = stcs_pkg::S_C_DIVS;
				end
			end
			stcs_pkg::S_WIN_READ: state_nx = stcs_pkg::S_WIN_UPD;
			stcs_pkg::S_WIN_UPD:  state_nx = stcs_pkg::S_WIN_DIVS;
			stcs_pkg::S_WIN_DIVS: state_nx = stcs_pkg::S_WIN_DIVW;
			stcs_pkg::S_WIN_DIVW: begin
				if (!status.div_busy)
					state_nx = stcs_pkg::S_WIN_MEAN;
			end
			stcs_pkg::S_WIN_MEAN: state_nx = stcs_pkg::S_BAND;
			stcs_pkg::S_BAND:     state_nx = stcs_pkg::S_DONE;
			stcs_pkg::S_C_DIVS:   state_nx = stcs_pkg::S_C_DIVW;
			stcs_pkg::S_C_DIVW: begin
				if (!status.div_busy)
					state_nx = stcs_pkg::S_C_MEAN;
			end
			stcs_pkg::S_C_MEAN: state_nx = stcs_pkg::S_C_MUL;
			stcs_pkg::S_C_MUL:  state_nx = stcs_pkg::S_C_ACC;
			stcs_pkg::S_C_ACC:  state_nx = stcs_pkg::S_C_CHK;
			stcs_pkg::S_C_CHK: begin
				state_nx = status.multi_sample ? stcs_pkg::S_C_DIV2S : stcs_pkg::S_C_END;
			end
			stcs_pkg::S_C_DIV2S: state_nx = stcs_pkg::S_C_DIV2W;
			stcs_pkg::S_C_DIV2W: begin
				if (!status.div_busy)
					state_nx = stcs_pkg::S_C_SQS;
			end
			stcs_pkg::S_C_SQS: state_nx = stcs_pkg::S_C_SQW;
			stcs_pkg::S_C_SQW: begin
				if (!status.sqrt_busy)
					state_nx = stcs_pkg::S_C_SPREAD;
			end
			stcs_pkg::S_C_SPREAD: state_nx = stcs_pkg::S_C_END;
			stcs_pkg::S_C_END:    state_nx = stcs_pkg::S_DONE;
			stcs_pkg::S_DONE: begin
				if (status.out_free)
					state_nx = stcs_pkg::S_WAIT;
			end
			default: state_nx = stcs_pkg::S_WAIT;
		endcase
	end

	always_comb begin
		op       = stcs_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			stcs_pkg::S_WAIT: begin
				in_ready = 1'b1;
				if (in_valid)
					op = stcs_pkg::OP_CAPTURE;
			end
			stcs_pkg::S_DECODE: begin
				case (status.req)
					stcs_pkg::REQ_BEGIN: begin
						if (status.begin_ok)
							op = stcs_pkg::OP_BEGIN;
					end
					stcs_pkg::REQ_TICK: begin
						if (status.phase == stcs_pkg::PH_EXCITE)
							op = stcs_pkg::OP_TO_SETTLE;
						else if (status.phase == stcs_pkg::PH_SETTLE) begin
							if (status.timed_out)
								op = stcs_pkg::OP_TO_NOGO;
							else if (status.win_zero)
								op = stcs_pkg::OP_WIN_INST;
						end
					end
					stcs_pkg::REQ_PASS: op = stcs_pkg::OP_TO_PASS;
					stcs_pkg::REQ_NOGO: op = stcs_pkg::OP_TO_NOGO;
					default:            op = stcs_pkg::OP_NONE;
				endcase
			end
			stcs_pkg::S_WIN_READ: op = stcs_pkg::OP_WIN_READ;
			stcs_pkg::S_WIN_UPD:  op = stcs_pkg::OP_WIN_UPD;
			stcs_pkg::S_WIN_DIVS: op = stcs_pkg::OP_WIN_DIV;
			stcs_pkg::S_WIN_MEAN: op = stcs_pkg::OP_WIN_MEAN;
			stcs_pkg::S_BAND:     op = stcs_pkg::OP_BAND;
			stcs_pkg::S_C_DIVS:   op = stcs_pkg::OP_C_DIV;
			stcs_pkg::S_C_MEAN:   op = stcs_pkg::OP_C_MEAN;
			stcs_pkg::S_C_MUL:    op = stcs_pkg::OP_C_MUL;
			stcs_pkg::S_C_ACC:    op = stcs_pkg::OP_C_ACC;
			stcs_pkg::S_C_DIV2S:  op = stcs_pkg::OP_C_DIV2;
			stcs_pkg::S_C_SQS:    op = stcs_pkg::OP_C_SQRT;
			stcs_pkg::S_C_SPREAD: op = stcs_pkg::OP_C_SPREAD;
			stcs_pkg::S_C_END:    op = stcs_pkg::OP_C_END;
			stcs_pkg::S_DONE: begin
				if (status.out_free)
					op = stcs_pkg::OP_OUT;
			end
			default: op = stcs_pkg::OP_NONE;
		endcase
	end
endmodule

// ----- rtl/stcs_datapath.sv -----
// state registers, sample window, statistics arithmetic and result register
module stcs_datapath #(
	parameter int WINDOW_DEPTH = stcs_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stcs_pkg::dp_op_t      op,
	input  stcs_pkg::cfg_t        cfg,
	input  logic [1:0]            in_req_type,
	input  logic signed [31:0]    in_sample_value,
	input  logic [31:0]           in_time_ms,
	input  logic                  out_ready,
	output stcs_pkg::dp_status_t  status,
	output logic                  out_valid,
	output logic [2:0]            out_phase_code,
	output logic signed [31:0]    out_stat_mean,
	output logic [30:0]           out_stat_spread,
	output logic signed [31:0]    out_smoothed_value,
	output logic [15:0]           out_samples_used
);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SW = 32 + FW;
	localparam int NW = stcs_pkg::DIVIDEND_W;
	localparam int DW = stcs_pkg::DIVISOR_W;

	// captured request
	stcs_pkg::req_t     req_q;
	logic signed [31:0] x_q;
	logic [31:0]        now_q;

	// run state
	stcs_pkg::phase_t   phase_q;
	logic [31:0]        start_q;
	logic [15:0]        band_run_q;
	logic [15:0]        count_q;
	logic signed [31:0] mean_q;
	logic [30:0]        spread_q;
	logic [63:0]        sq_q;
	logic signed [SW-1:0] wsum_q;
	logic signed [31:0] wmean_q;
	logic [FW-1:0]      fill_q;
	logic [HW-1:0]      head_q;

	// working registers
	logic signed [31:0] rd_q;
	logic               dneg_q;
	logic [31:0]        dabs_q;
	logic [31:0]        babs_q;
	logic [63:0]        prod_q;

	// result register
	logic               out_valid_q;
	stcs_pkg::phase_t   o_phase_q;
	logic signed [31:0] o_mean_q;
	logic [30:0]        o_spread_q;
	logic signed [31:0] o_wmean_q;
	logic [15:0]        o_count_q;

	logic signed [31:0] store [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] slot_valid_q;

	logic [FW-1:0]      w_eff;
	logic [HW-1:0]      h_eff;
	logic [FW-1:0]      head_inc;
	logic               win_ready;
	logic [15:0]        n_next;
	logic signed [32:0] d_s;
	logic [32:0]        d_abs;
	logic [31:0]        q32;
	logic signed [32:0] q_s;
	logic signed [32:0] mean_nx33;
	logic [31:0]        mean_nx;
	logic signed [32:0] d2_s;
	logic [32:0]        d2_abs;
	logic [64:0]        sq_sum;
	logic [SW-1:0]      wsum_abs;
	logic signed [32:0] dist_s;
	logic [32:0]        band_err;
	logic               in_band;
	logic [15:0]        run_nx;
	logic               div_start;
	logic [NW-1:0]      div_dividend;
	logic [DW-1:0]      div_divisor;
	logic               div_busy;
	logic [NW-1:0]      div_quo;
	logic               sqrt_busy;
	logic [31:0]        sqrt_root;
	logic               out_free;

	// effective window length and head after any length change
	always_comb begin
		if (32'(cfg.window_length) > WINDOW_DEPTH)
			w_eff = FW'(WINDOW_DEPTH);
		else
			w_eff = FW'(cfg.window_length);
		h_eff    = (FW'(head_q) >= w_eff) ? '0 : head_q;
		head_inc = FW'(head_q) + FW'(1);
	end

	assign win_ready = (w_eff == '0) || (fill_q >= w_eff);
	assign n_next    = (count_q != 16'hFFFF) ? count_q + 16'd1 : 16'hFFFF;

	// welford arithmetic
	assign d_s       = 33'(x_q) - 33'(mean_q);
	assign d_abs     = d_s[32] ? 33'(-d_s) : 33'(d_s);
	assign q32       = div_quo[31:0];
	assign q_s       = dneg_q ? -$signed({1'b0, q32}) : $signed({1'b0, q32});
	assign mean_nx33 = 33'(mean_q) + q_s;
	assign mean_nx   = mean_nx33[31:0];
	assign d2_s      = 33'(x_q) - 33'($signed(mean_nx));
	assign d2_abs    = d2_s[32] ? 33'(-d2_s) : 33'(d2_s);
	assign sq_sum    = {1'b0, sq_q} + {1'b0, prod_q};

	// window and band arithmetic
	assign wsum_abs = wsum_q[SW-1] ? SW'(-wsum_q) : SW'(wsum_q);
	assign dist_s   = 33'(wmean_q) - 33'(cfg.target_level);
	assign band_err = dist_s[32] ? 33'(-dist_s) : 33'(dist_s);
	assign in_band  = win_ready && (band_err <= {2'b00, cfg.band_width});
	assign run_nx   = in_band ? ((band_run_q != 16'hFFFF) ? band_run_q + 16'd1 : band_run_q)
		: 16'd0;

	// shared divider operand selection
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (op)
			stcs_pkg::OP_WIN_DIV: begin
				div_start    = 1'b1;
				div_dividend = NW'(wsum_abs);
				div_divisor  = DW'(fill_q);
			end
			stcs_pkg::OP_C_DIV: begin
				div_start    = 1'b1;
				div_dividend = NW'(d_abs[31:0]);
				div_divisor  = n_next;
			end
			stcs_pkg::OP_C_DIV2: begin
				div_start    = 1'b1;
				div_dividend = sq_q;
				div_divisor  = count_q - 16'd1;
			end
			default: div_start = 1'b0;
		endcase
	end

	stcs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	stcs_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (op == stcs_pkg::OP_C_SQRT),
		.operand (div_quo),
		.busy    (sqrt_busy),
		.root    (sqrt_root)
	);

	// one valid bit per slot: slots not written since the last begin read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slot_valid_q <= '0;
		else if (op == stcs_pkg::OP_BEGIN)
			slot_valid_q <= '0;
		else if (op == stcs_pkg::OP_WIN_UPD)
			slot_valid_q[head_q] <= 1'b1;
	end

	// sample window memory
	always_ff @(posedge clk) begin
		if (op == stcs_pkg::OP_WIN_UPD)
			store[head_q] <= x_q;
		if (op == stcs_pkg::OP_WIN_READ)
			rd_q <= slot_valid_q[h_eff] ? store[h_eff] : '0;
	end

	// captured request and working registers
	always_ff @(posedge clk) begin
		if (op == stcs_pkg::OP_CAPTURE) begin
			x_q   <= in_sample_value;
			now_q <= in_time_ms;
		end
		if (op == stcs_pkg::OP_C_DIV) begin
			dneg_q <= d_s[32];
			dabs_q <= d_abs[31:0];
		end
		if (op == stcs_pkg::OP_C_MEAN)
			babs_q <= d2_abs[31:0];
		if (op == stcs_pkg::OP_C_MUL)
			prod_q <= dabs_q * babs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q      <= stcs_pkg::REQ_BEGIN;
			phase_q    <= stcs_pkg::PH_IDLE;
			start_q    <= '0;
			band_run_q <= '0;
			count_q    <= '0;
			mean_q     <= '0;
			spread_q   <= '0;
			sq_q       <= '0;
			wsum_q     <= '0;
			wmean_q    <= '0;
			fill_q     <= '0;
			head_q     <= '0;
		end else begin
			case (op)
				stcs_pkg::OP_CAPTURE: req_q <= stcs_pkg::req_t'(in_req_type);
				stcs_pkg::OP_BEGIN: begin
					phase_q    <= stcs_pkg::PH_EXCITE;
					start_q    <= now_q;
					band_run_q <= '0;
					count_q    <= '0;
					mean_q     <= '0;
					spread_q   <= '0;
					sq_q       <= '0;
					wsum_q     <= '0;
					wmean_q    <= '0;
					fill_q     <= '0;
					head_q     <= '0;
				end
				stcs_pkg::OP_TO_SETTLE: phase_q <= stcs_pkg::PH_SETTLE;
				stcs_pkg::OP_TO_PASS:   phase_q <= stcs_pkg::PH_PASS;
				stcs_pkg::OP_TO_NOGO:   phase_q <= stcs_pkg::PH_NOGO;
				stcs_pkg::OP_WIN_INST:  wmean_q <= x_q;
				stcs_pkg::OP_WIN_READ:  head_q  <= h_eff;
				stcs_pkg::OP_WIN_UPD: begin
					if (fill_q < w_eff) begin
						fill_q <= fill_q + FW'(1);
						wsum_q <= wsum_q + SW'(x_q);
					end else begin
						wsum_q <= wsum_q - SW'(rd_q) + SW'(x_q);
					end
					head_q <= (head_inc == w_eff) ? '0 : HW'(head_inc);
				end
				stcs_pkg::OP_WIN_MEAN: begin
					wmean_q <= wsum_q[SW-1] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
				end
				stcs_pkg::OP_BAND: begin
					band_run_q <= run_nx;
					if (run_nx >= cfg.hold_ticks) begin
						phase_q  <= stcs_pkg::PH_COLLECT;
						count_q  <= '0;
						mean_q   <= '0;
						spread_q <= '0;
						sq_q     <= '0;
					end
				end
				stcs_pkg::OP_C_MEAN: mean_q <= $signed(mean_nx);
				stcs_pkg::OP_C_ACC: begin
					sq_q     <= sq_sum[64] ? '1 : sq_sum[63:0];
					count_q  <= n_next;
					spread_q <= '0;
				end
				stcs_pkg::OP_C_SPREAD: spread_q <= sqrt_root[31] ? 31'h7FFF_FFFF : sqrt_root[30:0];
				stcs_pkg::OP_C_END: begin
					if (count_q >= cfg.collect_count) begin
						if (!cfg.spread_limit[31] && cfg.spread_limit != 32'sd0
								&& {1'b0, spread_q} > cfg.spread_limit[31:0])
							phase_q <= stcs_pkg::PH_NOGO;
						else
							phase_q <= stcs_pkg::PH_EVALUATE;
					end
				end
				default: phase_q <= phase_q;
			endcase
		end
	end

	// result register parts the output handshake from the sequencer
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (op == stcs_pkg::OP_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (op == stcs_pkg::OP_OUT) begin
			o_phase_q  <= phase_q;
			o_mean_q   <= mean_q;
			o_spread_q <= spread_q;
			o_wmean_q  <= wmean_q;
			o_count_q  <= count_q;
		end
	end

	always_comb begin
		status.req          = req_q;
		status.phase        = phase_q;
		status.begin_ok     = (cfg.hold_ticks != '0) && (cfg.collect_count != '0)
			&& (cfg.timeout_limit != '0);
		status.timed_out    = (now_q - start_q) > cfg.timeout_limit;
		status.win_zero     = (w_eff == '0);
		status.multi_sample = (count_q > 16'd1);
		status.div_busy     = div_busy;
		status.sqrt_busy    = sqrt_busy;
		status.out_free     = out_free;
	end

	assign out_valid          = out_valid_q;
	assign out_phase_code     = o_phase_q;
	assign out_stat_mean      = o_mean_q;
	assign out_stat_spread    = o_spread_q;
	assign out_smoothed_value = o_wmean_q;
	assign out_samples_used   = o_count_q;
endmodule

// ----- rtl/settle_then_collect_stats_unit.sv -----
// top level of the settle-then-collect calibration statistics unit
// Every request transaction (begin, tick, mark pass, force nogo) yields exactly one result
// transaction carrying the phase and statistics after the update. Requests are handled one at
// a time by the sequencer; a result waits in its own register, so the next request is taken
// while the previous result is still unclaimed. A settle tick with a sliding window makes one
// pass of the shared 2-bit-per-cycle divider for the window mean; with a zero window length it
// skips the divider. A collect tick makes one divider pass for the Welford mean and, from the
// second sample on, a second for the squared-deviation sum over n-1 and one pass of the
// bit-serial square root. No clearing pass after reset or begin: one valid bit per window slot
// makes slots not written since the last begin read as zero.
module settle_then_collect_stats_unit #(
	parameter int WINDOW_DEPTH = stcs_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	stcs_req_if.sink                            req,
	stcs_res_if.source                          res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [stcs_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	stcs_pkg::cfg_t       cfg_q;
	stcs_pkg::dp_status_t status;
	stcs_pkg::dp_op_t     op;
	stcs_pkg::reg_idx_t   reg_idx;
	logic                 cfg_wr;
	logic                 in_ready;

	// apb access: no wait states
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = stcs_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level  <= '0;
			cfg_q.band_width    <= '0;
			cfg_q.hold_ticks    <= stcs_pkg::HOLD_TICKS_RST;
			cfg_q.collect_count <= stcs_pkg::COLLECT_COUNT_RST;
			cfg_q.timeout_limit <= stcs_pkg::TIMEOUT_LIMIT_RST;
			cfg_q.window_length <= '0;
			cfg_q.spread_limit  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				stcs_pkg::REG_TARGET:  cfg_q.target_level  <= $signed(pwdata);
				stcs_pkg::REG_BAND:    cfg_q.band_width    <= pwdata[30:0];
				stcs_pkg::REG_HOLD:    cfg_q.hold_ticks    <= pwdata[15:0];
				stcs_pkg::REG_COLLECT: cfg_q.collect_count <= pwdata[15:0];
				stcs_pkg::REG_TIMEOUT: cfg_q.timeout_limit <= pwdata;
				stcs_pkg::REG_WINDOW:  cfg_q.window_length <= pwdata[4:0];
				stcs_pkg::REG_SPREAD:  cfg_q.spread_limit  <= $signed(pwdata);
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	// register readback, unused addresses read as zero
	always_comb begin
		case (reg_idx)
			stcs_pkg::REG_TARGET:  prdata = cfg_q.target_level;
			stcs_pkg::REG_BAND:    prdata = {1'b0, cfg_q.band_width};
			stcs_pkg::REG_HOLD:    prdata = {16'd0, cfg_q.hold_ticks};
			stcs_pkg::REG_COLLECT: prdata = {16'd0, cfg_q.collect_count};
			stcs_pkg::REG_TIMEOUT: prdata = cfg_q.timeout_limit;
			stcs_pkg::REG_WINDOW:  prdata = {27'd0, cfg_q.window_length};
			stcs_pkg::REG_SPREAD:  prdata = cfg_q.spread_limit;
			default:               prdata = '0;
		endcase
	end

	assign req.ready = in_ready;

	// sequencer: one request transaction at a time
	stcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.op       (op)
	);

	// state, window, statistics and result register
	stcs_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.op                 (op),
		.cfg                (cfg_q),
		.in_req_type        (req.req_type),
		.in_sample_value    (req.sample_value),
		.in_time_ms         (req.time_ms),
		.out_ready          (res.ready),
		.status             (status),
		.out_valid          (res.valid),
		.out_phase_code     (res.phase_code),
		.out_stat_mean      (res.stat_mean),
		.out_stat_spread    (res.stat_spread),
		.out_smoothed_value (res.smoothed_value),
		.out_samples_used   (res.samples_used)
	);
endmodule

// ----- rtl/stcs_checker.sv -----
// port-level checks on the settle-then-collect statistics unit, with bind
module stcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  phase_code,
	input logic [30:0] stat_spread,
	input logic [15:0] samples_used
);
	// a held result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time: no new request right after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in progress");

	// excite is only entered by a begin, which clears the statistics
	a_excite_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_code == stcs_pkg::PH_EXCITE
		|-> samples_used == 16'd0 && stat_spread == 31'd0)
		else $error("statistics not cleared in excite");

	// spread is defined only from two samples on
	a_spread_samples: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && samples_used < 16'd2 |-> stat_spread == 31'd0)
		else $error("spread reported below two samples");
endmodule

bind settle_then_collect_stats_unit stcs_checker u_stcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.phase_code   (res.phase_code),
	.stat_spread  (res.stat_spread),
	.samples_used (res.samples_used)
);

// ----- tb/sv/stcs_result_checker.sv -----
`timescale 1ns / 1ps
// result checker: tracks register writes, predicts each result and compares it
module stcs_result_checker
	import stcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	stcs_req_if         req_mon,
	stcs_res_if         res_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		phase_t             phase;
		logic signed [31:0] mean;
		logic [30:0]        spread;
		logic signed [31:0] smoothed;
		logic [15:0]        used;
	} calib_out_t;

	cfg_t cfg;

	phase_t                   phase_q;
	logic [31:0]              start_ms;
	logic [15:0]              band_streak;
	logic [15:0]              n_gathered;
	logic signed [31:0]       run_mean;
	logic [31:0]              run_spread;
	longint unsigned          sq_dev;
	longint                   win_sum;
	logic signed [31:0]       win_mean;
	int unsigned              win_fill;
	int unsigned              wr_slot;
	logic signed [31:0]       win_buf [16];

	calib_out_t expected_q[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void clear_calib_run();
		band_streak = 0;
		n_gathered = 0;
		run_mean = 0;
		run_spread = 0;
		sq_dev = 0;
		win_sum = 0;
		win_mean = 0;
		win_fill = 0;
		wr_slot = 0;
		foreach (win_buf[i]) win_buf[i] = 0;
	endfunction

	function automatic void settle_step(logic signed [31:0] x, logic [31:0] now);
		int unsigned w;
		longint gap;
		logic [31:0] elapsed;
		logic signed [31:0] m;
		w = (cfg.window_length > 16) ? 16 : cfg.window_length;
		elapsed = now - start_ms;
		if (elapsed > cfg.timeout_limit) begin
			phase_q = PH_NOGO;
			return;
		end
		if (w == 0) begin
			win_mean = x;
		end else begin
			if (wr_slot >= w) wr_slot = 0;
			if (win_fill < w) win_fill++;
			else win_sum -= longint'(win_buf[wr_slot]);
			win_buf[wr_slot] = x;
			win_sum += longint'(x);
			wr_slot = (wr_slot + 1) % w;
			win_mean = 32'(win_sum / longint'(win_fill));
		end
		m = win_mean;
		gap = longint'(m) - longint'(cfg.target_level);
		if (gap < 0) gap = -gap;
		if ((w == 0 || win_fill >= w) && gap <= longint'({1'b0, cfg.band_width})) begin
			if (band_streak != 16'hFFFF) band_streak++;
		end else begin
			band_streak = 0;
		end
		if (band_streak >= cfg.hold_ticks) begin
			phase_q = PH_COLLECT;
			n_gathered = 0;
			run_mean = 0;
			run_spread = 0;
			sq_dev = 0;
		end
	endfunction

	function automatic void welford_step(logic signed [31:0] x);
		int unsigned n;
		longint d, d2;
		longint unsigned a, b, p, s;
		n = (n_gathered != 16'hFFFF) ? n_gathered + 1 : 65535;
		d = longint'(x) - longint'(run_mean);
		run_mean = 32'(longint'(run_mean) + d / longint'(n));
		d2 = longint'(x) - longint'(run_mean);
		a = (d < 0) ? -d : d;
		b = (d2 < 0) ? -d2 : d2;
		p = a * b;
		sq_dev = (sq_dev > ~p) ? 64'hFFFF_FFFF_FFFF_FFFF : sq_dev + p;
		n_gathered = 16'(n);
		if (n > 1) begin
			s = int_sqrt(sq_dev / longint'(n - 1));
			run_spread = (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
		end else begin
			run_spread = 0;
		end
		if (n >= cfg.collect_count) begin
			if (cfg.spread_limit > 0 && longint'(run_spread) > longint'(cfg.spread_limit))
				phase_q = PH_NOGO;
			else
				phase_q = PH_EVALUATE;
		end
	endfunction

	function automatic calib_out_t predict_request(req_t r, logic signed [31:0] x,
		logic [31:0] now);
		calib_out_t o;
		case (r)
			REQ_BEGIN: begin
				if (cfg.hold_ticks != 0 && cfg.collect_count != 0 && cfg.timeout_limit != 0) begin
					clear_calib_run();
					start_ms = now;
					phase_q = PH_EXCITE;
				end
			end
			REQ_TICK: begin
				if (phase_q == PH_EXCITE) phase_q = PH_SETTLE;
				else if (phase_q == PH_SETTLE) settle_step(x, now);
				else if (phase_q == PH_COLLECT) welford_step(x);
			end
			REQ_PASS: phase_q = PH_PASS;
			default:  phase_q = PH_NOGO;
		endcase
		o.phase = phase_q;
		o.mean = run_mean;
		o.spread = run_spread[30:0];
		o.smoothed = win_mean;
		o.used = n_gathered;
		return o;
	endfunction

	initial begin
		cfg = '0;
		cfg.hold_ticks = HOLD_TICKS_RST;
		cfg.collect_count = COLLECT_COUNT_RST;
		cfg.timeout_limit = TIMEOUT_LIMIT_RST;
		phase_q = PH_IDLE;
		start_ms = 0;
		clear_calib_run();
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		calib_out_t e, got;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_TARGET:  cfg.target_level = pwdata;
					REG_BAND:    cfg.band_width = pwdata[30:0];
					REG_HOLD:    cfg.hold_ticks = pwdata[15:0];
					REG_COLLECT: cfg.collect_count = pwdata[15:0];
					REG_TIMEOUT: cfg.timeout_limit = pwdata;
					REG_WINDOW:  cfg.window_length = pwdata[4:0];
					REG_SPREAD:  cfg.spread_limit = pwdata;
					default: ;
				endcase
			end
			if (req_mon.valid && req_mon.ready)
				expected_q.push_back(predict_request(req_t'(req_mon.req_type),
					req_mon.sample_value, req_mon.time_ms));
			if (res_mon.valid && res_mon.ready) begin
				got = {phase_t'(res_mon.phase_code), res_mon.stat_mean, res_mon.stat_spread,
					res_mon.smoothed_value, res_mon.samples_used};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction: %h", got);
				end else begin
					e = expected_q.pop_front();
					if (e != got) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result differs: phase %0d/%0d mean %0d/%0d ",
								"spread %0d/%0d smoothed %0d/%0d used %0d/%0d (exp/got)"},
								e.phase, got.phase, e.mean, got.mean, e.spread, got.spread,
								e.smoothed, got.smoothed, e.used, got.used);
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_settle_then_collect_stats_unit.sv -----
`timescale 1ns / 1ps
// top of the testbench: clock, reset, request and register stimulus, verdict
module tb_settle_then_collect_stats_unit;
	import stcs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	stcs_req_if req_ch();
	stcs_res_if res_ch();

	settle_then_collect_stats_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	stcs_result_checker chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req_ch), .res_mon(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
	);

	// live copy of the settings that matter for building well-formed runs
	logic signed [31:0] cur_target;
	logic [30:0]        cur_band;
	int                 cur_hold, cur_collect, cur_window;
	logic [31:0]        now_ms;
	int                 burst_left;

	// long hold-off on the result side, requested by toggling hold_trig
	logic hold_trig, hold_seen;
	int   hold_left;
	logic [11:0] stall_phase;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: stall pattern cycles through always-ready, sparse, periodic and coin-flip
	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= 400;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1;
			case (stall_phase[11:10])
				2'd0: res_ch.ready <= 1'b1;
				2'd1: res_ch.ready <= ($urandom_range(0, 3) == 0);
				2'd2: res_ch.ready <= (stall_phase[2:0] != 3'd0);
				default: res_ch.ready <= $urandom_range(0, 1);
			endcase
		end
	end

	// offer one request transaction and hold it until taken; gaps fall between bursts
	task automatic send_req(req_t r, logic signed [31:0] x, logic [31:0] t);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r;
		req_ch.sample_value <= x;
		req_ch.time_ms <= t;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	// apb write: setup cycle then access cycle
	task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// registers only change once every result is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(logic signed [31:0] tgt, logic [30:0] band, int hold,
		int coll, logic [31:0] tmo, int win, logic signed [31:0] spread);
		drain();
		cfg_write(REG_TARGET, tgt);
		cfg_write(REG_BAND, {1'b0, band});
		cfg_write(REG_HOLD, 32'(hold));
		cfg_write(REG_COLLECT, 32'(coll));
		cfg_write(REG_TIMEOUT, tmo);
		cfg_write(REG_WINDOW, 32'(win));
		cfg_write(REG_SPREAD, spread);
		cur_target = tgt;
		cur_band = band;
		cur_hold = hold;
		cur_collect = coll;
		cur_window = win;
	endtask

	// sample close to the target, mostly inside the band
	function automatic logic signed [31:0] near_target();
		longint off;
		longint span;
		span = (cur_band > 0) ? longint'(cur_band) : 1;
		if (span > 64'd200000) span = 200000;
		off = longint'($urandom_range(0, 32'(2 * span))) - span;
		if ($urandom_range(0, 15) == 0) off = off * 4;
		return 32'(longint'(cur_target) + off);
	endfunction

	// one calibration run: begin, excite, settle, collect, then a closing request
	task automatic calib_run(output int n_items);
		int settle_n, coll_n, w;
		n_items = 0;
		now_ms += $urandom_range(0, 50);
		send_req(REQ_BEGIN, $urandom, now_ms);
		send_req(REQ_TICK, $urandom, now_ms);
		n_items += 2;
		w = (cur_window > 16) ? 16 : cur_window;
		settle_n = w + cur_hold + $urandom_range(0, 3);
		if (settle_n > 40) settle_n = 40;
		for (int i = 0; i < settle_n; i++) begin
			now_ms += $urandom_range(0, 2);
			// occasionally jump far enough to trip the settle timeout
			if ($urandom_range(0, 60) == 0) now_ms += 32'd5000;
			send_req(REQ_TICK, near_target(), now_ms);
			n_items++;
		end
		coll_n = cur_collect + $urandom_range(0, 2);
		if (coll_n > 24) coll_n = 24;
		for (int i = 0; i < coll_n; i++) begin
			send_req(REQ_TICK, ($urandom_range(0, 7) == 0) ? 32'($urandom) : near_target(),
				now_ms);
			n_items++;
		end
		case ($urandom_range(0, 3))
			0: send_req(REQ_PASS, $urandom, now_ms);
			1: send_req(REQ_NOGO, $urandom, now_ms);
			default: send_req(REQ_TICK, $urandom, now_ms);
		endcase
		n_items++;
	endtask

	initial begin
		#20_000_000;
		$display("settle_then_collect_stats_unit: mismatch");
		$finish;
	end

	initial begin
		int done_items, got;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_BEGIN;
		req_ch.sample_value = '0;
		req_ch.time_ms = '0;
		res_ch.ready = 1'b0;
		hold_trig = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		stall_phase = '0;
		burst_left = 0;
		now_ms = 0;
		cur_target = 0;
		cur_band = 0;
		cur_hold = 1;
		cur_collect = 1;
		cur_window = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, requests outside a run, a full run, timeout, time wrap
		send_req(REQ_TICK, 32'h7FFF_FFFF, 32'd0);
		send_req(REQ_PASS, 32'h8000_0000, 32'hFFFF_FFFF);
		send_req(REQ_NOGO, 32'd0, 32'd0);
		send_req(REQ_BEGIN, 32'd0, 32'd5);
		send_req(REQ_TICK, 32'd0, 32'd5);
		send_req(REQ_TICK, 32'd0, 32'd6);
		send_req(REQ_TICK, 32'h7FFF_FFFF, 32'd6);
		send_req(REQ_TICK, 32'h8000_0000, 32'd7);
		send_req(REQ_BEGIN, 32'd0, 32'd10);
		send_req(REQ_TICK, 32'd0, 32'd10);
		send_req(REQ_TICK, 32'd0, 32'd2000);
		send_req(REQ_BEGIN, 32'd0, 32'hFFFF_FFF0);
		send_req(REQ_TICK, 32'd0, 32'hFFFF_FFF0);
		send_req(REQ_TICK, 32'h8000_0000, 32'd5);
		send_req(REQ_PASS, 32'd0, 32'd5);
		// begin ignored for each zero-valued guard
		apply_settings(0, 0, 0, 1, 1000, 0, 0);
		send_req(REQ_BEGIN, 32'd0, 32'd1);
		apply_settings(0, 0, 1, 0, 1000, 0, 0);
		send_req(REQ_BEGIN, 32'd0, 32'd1);
		apply_settings(0, 0, 1, 1, 0, 0, 0);
		send_req(REQ_BEGIN, 32'd0, 32'd1);
		// extremes: widest band, longest window, tight spread limit
		apply_settings(32'h8000_0000, 31'h7FFF_FFFF, 2, 3, 32'hFFFF_FFFF, 31, 1);
		send_req(REQ_BEGIN, 32'd0, 32'd0);
		send_req(REQ_TICK, 32'd0, 32'd0);
		send_req(REQ_TICK, 32'h7FFF_FFFF, 32'd1);
		send_req(REQ_TICK, 32'h8000_0000, 32'd2);

		// random phases, each with its own settings
		done_items = 0;
		for (int ph = 0; done_items < 1200; ph++) begin
			case (ph % 6)
				0: apply_settings($urandom, $urandom_range(0, 20000), $urandom_range(1, 5),
					$urandom_range(1, 8), $urandom_range(50, 3000), $urandom_range(0, 8),
					$urandom_range(0, 1) ? 0 : $urandom);
				1: apply_settings(32'h7FFF_FFFF, 31'h7FFF_FFFF, 65535, 65535, 32'hFFFF_FFFF,
					16, 32'h7FFF_FFFF);
				2: apply_settings($urandom, $urandom, $urandom_range(1, 3),
					$urandom_range(1, 12), 32'd1, $urandom_range(0, 31),
					$urandom_range(1, 40000));
				3: apply_settings(32'h8000_0000, 0, 1, 1, 32'd1000, 1, 32'h8000_0000);
				4: apply_settings($urandom, $urandom_range(100, 400000), $urandom_range(1, 6),
					$urandom_range(2, 20), $urandom, $urandom_range(9, 31), $urandom);
				default: apply_settings(0, $urandom_range(0, 100000), $urandom_range(1, 8),
					$urandom_range(1, 10), $urandom_range(100, 60000), $urandom_range(0, 16),
					$urandom_range(1, 300000));
			endcase
			if (ph == 2) hold_trig = ~hold_trig;
			for (int k = 0; k < 6; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: any request, any field values
					repeat ($urandom_range(1, 6)) begin
						send_req(req_t'($urandom_range(0, 3)), $urandom, $urandom);
						done_items++;
					end
				end else begin
					calib_run(got);
					done_items += got;
				end
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("settle_then_collect_stats_unit: match");
		else
			$display("settle_then_collect_stats_unit: mismatch");
		$finish;
	end

endmodule
